// File: design/csv_escaped_field_splitter_top_defines.svh
// Assertion macros shared by the checker file of the CSV field splitter.
`ifndef CSV_ESCAPED_FIELD_SPLITTER_TOP_DEFINES_SVH
`define CSV_ESCAPED_FIELD_SPLITTER_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define CSVFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define CSVFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define CSVFS_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/csvfs_pkg.sv
// Types and constants of the CSV field splitter.
`timescale 1ns / 1ps
`default_nettype none
package csvfs_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_N  = 8'h6E;

  localparam logic [31:0] ESCAPE_SET_RST    = 32'h0000_005C;
  localparam logic [31:0] SEPARATOR_SET_RST = 32'h0000_002C;
  localparam logic [31:0] QUOTE_SET_RST     = 32'h0000_0022;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ESCAPE_SET    = 3'd0,
    CFG_SEPARATOR_SET = 3'd1,
    CFG_QUOTE_SET     = 3'd2,
    CFG_MATCH_QUOTES  = 3'd3,
    CFG_CRLF          = 3'd4
  } cfg_idx_t;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } res_t;

  localparam res_t RES_END = '{kind: KIND_END, ch: 8'h00};

endpackage
`default_nettype wire

// File: design/csv_escaped_field_splitter_top.sv
// Top level of the CSV field splitter: escape, quote and separator handling.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid / in_stall   | in_char, in_end_of_stream
//  out_    | output    | out_valid / out_stall | out_kind, out_char, out_last_of_run
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An item is held in an input register and decoded into a result buffer of up
// to three results, which drains one result per cycle while out_stall is low.
// The buffer loads the next item when empty or as its last result is taken.
// A new item is taken while the previous item's results wait in the buffer.
// Reset is synchronous; it clears the handshake and tokenizer state and loads
// the configuration registers with their defaults; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module csv_escaped_field_splitter_top
  import csvfs_pkg::*;
#(
  parameter int SET_SLOTS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [7:0]           in_char,
  input  wire logic                 in_end_of_stream,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic                 out_kind,
  output      logic [7:0]           out_char,
  output      logic                 out_last_of_run,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  // Slots past the 32-bit register are not checked; a zero slot never matches.
  localparam int USED_SLOTS = (SET_SLOTS < 4) ? SET_SLOTS : 4;

  function automatic logic in_set(input logic [31:0] set, input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < USED_SLOTS; i++) begin
      if ((set[8*i +: 8] != 8'h00) && (set[8*i +: 8] == c)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  logic [31:0] escape_set_r;
  logic [31:0] separator_set_r;
  logic [31:0] quote_set_r;
  logic        match_quotes_r;
  logic        crlf_r;

  logic        in_quotes_r, in_quotes_nxt;
  logic [7:0]  open_quote_r, open_quote_nxt;
  logic        esc_pending_r, esc_pending_nxt;

  logic        ir_valid_r;
  logic [7:0]  ir_char_r;
  logic        ir_eos_r;

  res_t        res_r [3];
  logic [1:0]  cnt_r;

  logic        out_take;
  logic        load_en;
  logic        in_take;

  logic        is_esc, is_sep, is_quote;
  logic [1:0]  ch_n, end_n, total;
  logic [7:0]  ch0, ch1;
  res_t        ent [3];

  assign cfg_ready = 1'b1;

  assign out_valid       = (cnt_r != 2'd0);
  assign out_kind        = res_r[0].kind;
  assign out_char        = res_r[0].ch;
  assign out_last_of_run = (cnt_r == 2'd1);

  assign out_take = out_valid && !out_stall;
  assign load_en  = ir_valid_r && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_take));
  assign in_stall = ir_valid_r && !load_en;
  assign in_take  = in_valid && !in_stall;

  assign is_esc   = in_set(escape_set_r, ir_char_r);
  assign is_sep   = in_set(separator_set_r, ir_char_r);
  assign is_quote = in_set(quote_set_r, ir_char_r);

  always_comb begin
    ch_n            = 2'd0;
    end_n           = 2'd0;
    ch0             = ir_char_r;
    ch1             = CH_LF;
    in_quotes_nxt   = in_quotes_r;
    open_quote_nxt  = open_quote_r;
    esc_pending_nxt = esc_pending_r;
    if (esc_pending_r) begin
      esc_pending_nxt = 1'b0;
      if (ir_char_r == CH_N) begin
        if (crlf_r) begin
          ch_n = 2'd2;
          ch0  = CH_CR;
        end else begin
          ch_n = 2'd1;
          ch0  = CH_LF;
        end
      end else begin
        ch_n = 2'd1;
      end
      end_n = {1'b0, ir_eos_r};
    end else if (is_esc) begin
      // A lone escape at the end of the stream is kept as a literal.
      if (ir_eos_r) begin
        ch_n  = 2'd1;
        end_n = 2'd1;
      end else begin
        esc_pending_nxt = 1'b1;
      end
    end else if (is_sep && !in_quotes_r) begin
      // A trailing separator closes the token and adds an empty one.
      end_n = ir_eos_r ? 2'd2 : 2'd1;
    end else if (is_quote && !is_sep &&
                 (!in_quotes_r || !match_quotes_r || (open_quote_r == ir_char_r))) begin
      open_quote_nxt = ir_char_r;
      in_quotes_nxt  = !in_quotes_r;
      end_n          = {1'b0, ir_eos_r};
    end else begin
      ch_n  = 2'd1;
      end_n = {1'b0, ir_eos_r};
    end
    if (end_n != 2'd0) begin
      in_quotes_nxt   = 1'b0;
      open_quote_nxt  = 8'h00;
      esc_pending_nxt = 1'b0;
    end
    total  = ch_n + end_n;
    ent[0] = (ch_n != 2'd0) ? res_t'{kind: KIND_CHAR, ch: ch0} : RES_END;
    ent[1] = (ch_n == 2'd2) ? res_t'{kind: KIND_CHAR, ch: ch1} : RES_END;
    ent[2] = RES_END;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_set_r    <= ESCAPE_SET_RST;
      separator_set_r <= SEPARATOR_SET_RST;
      quote_set_r     <= QUOTE_SET_RST;
      match_quotes_r  <= 1'b1;
      crlf_r          <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ESCAPE_SET:    escape_set_r    <= cfg_data;
        CFG_SEPARATOR_SET: separator_set_r <= cfg_data;
        CFG_QUOTE_SET:     quote_set_r     <= cfg_data;
        CFG_MATCH_QUOTES:  match_quotes_r  <= cfg_data[0];
        CFG_CRLF:          crlf_r          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r    <= 1'b0;
      cnt_r         <= 2'd0;
      in_quotes_r   <= 1'b0;
      open_quote_r  <= 8'h00;
      esc_pending_r <= 1'b0;
    end else begin
      if (in_take) begin
        ir_valid_r <= 1'b1;
      end else if (load_en) begin
        ir_valid_r <= 1'b0;
      end
      if (load_en) begin
        cnt_r         <= total;
        in_quotes_r   <= in_quotes_nxt;
        open_quote_r  <= open_quote_nxt;
        esc_pending_r <= esc_pending_nxt;
      end else if (out_take) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ir_char_r <= in_char;
      ir_eos_r  <= in_end_of_stream;
    end
    if (load_en) begin
      res_r[0] <= ent[0];
      res_r[1] <= ent[1];
      res_r[2] <= ent[2];
    end else if (out_take) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

endmodule
`default_nettype wire

// File: design/csvfs_checker.sv
// Port-level checker for the CSV field splitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "csv_escaped_field_splitter_top_defines.svh"
module csvfs_checker
  import csvfs_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic [7:0]           in_char,
  input wire logic                 in_end_of_stream,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 out_kind,
  input wire logic [7:0]           out_char,
  input wire logic                 out_last_of_run,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [31:0]          cfg_data
);

  logic out_held;
  logic in_held;
  logic cfg_seen;

  assign out_held = out_valid && out_stall;
  assign in_held  = in_valid && in_stall && in_end_of_stream && (in_char != 8'h00);
  assign cfg_seen = cfg_valid && cfg_ready && (cfg_index != cfg_index) && (cfg_data != cfg_data);

  `CSVFS_ASSERT_NEXT(a_out_valid_holds, out_held, out_valid, "result item dropped while stalled")
  `CSVFS_ASSERT_NEXT(a_out_payload_holds, out_held, $stable(out_kind) && $stable(out_char) && $stable(out_last_of_run), "stalled result item changed")
  `CSVFS_ASSERT_IMP(a_end_mark_char, out_valid && (out_kind == KIND_END), out_char == 8'h00, "token end mark carries a character")
  `CSVFS_ASSERT_ALWAYS_NEXT(a_reset_empty, !rst_n || cfg_seen || (in_held && !rst_n), !out_valid, "result item shown after reset")

endmodule

bind csv_escaped_field_splitter_top csvfs_checker u_csvfs_checker (.*);
`default_nettype wire
